// File: rtl/core/psrl_pkg.sv
// Shared types, constants and helpers for the per-source connection rate limiter.
`timescale 1ns / 1ps
`default_nettype none
package psrl_pkg;

	localparam int SLOTS     = 16;
	localparam int TRIES     = 4;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int TIME_N    = SLOTS * TRIES;
	localparam int TIME_AW   = $clog2(TIME_N);
	localparam int TCNT_W    = $clog2(TRIES + 1);
	localparam int ADDR_W    = 32;
	localparam int SEC_W     = 32;
	localparam int DELAY_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_CONNECT_DELAY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_VERIFY  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_SLOT_RD,
		S_SLOT_CHK,
		S_TIME,
		S_TIME_END,
		S_UPD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot_ra;
		logic               slot_we;
		logic [SLOT_W-1:0]  slot_wa;
		logic [ADDR_W-1:0]  slot_wd_addr;
		logic [SEC_W-1:0]   slot_wd_blk;
		logic [TIME_AW-1:0] time_ra;
		logic               time_we;
		logic [TIME_AW-1:0] time_wa;
		logic [SEC_W-1:0]   time_wd;
	} store_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] slot_addr;
		logic [SEC_W-1:0]  slot_blk;
		logic [SEC_W-1:0]  time_val;
	} store_rsp_t;

	function automatic logic [SEC_W-1:0] sat_add(input logic [SEC_W-1:0] a,
		input logic [DELAY_W-1:0] b);
		logic [SEC_W:0] s;
		s = {1'b0, a} + {{(SEC_W + 1 - DELAY_W){1'b0}}, b};
		return s[SEC_W] ? {SEC_W{1'b1}} : s[SEC_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/psrl_store.sv
// Slot and attempt-time memories with per-entry valid bits; reads registered.
`timescale 1ns / 1ps
`default_nettype none
module psrl_store
	import psrl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire store_req_t req,
	output store_rsp_t      rsp
);

	logic [ADDR_W+SEC_W-1:0] slot_mem [SLOTS];
	logic [SEC_W-1:0]        time_mem [TIME_N];
	logic [SLOTS-1:0]        slot_vld_q;
	logic [TIME_N-1:0]       time_vld_q;
	logic [ADDR_W+SEC_W-1:0] slot_rd_s1;
	logic [SEC_W-1:0]        time_rd_s1;
	logic                    slot_rv_s1;
	logic                    time_rv_s1;

	always_ff @(posedge clk) begin
		if (req.slot_we) begin
			slot_mem[req.slot_wa] <= {req.slot_wd_addr, req.slot_wd_blk};
		end
		if (req.time_we) begin
			time_mem[req.time_wa] <= req.time_wd;
		end
		slot_rd_s1 <= slot_mem[req.slot_ra];
		time_rd_s1 <= time_mem[req.time_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			time_vld_q <= '0;
			slot_rv_s1 <= 1'b0;
			time_rv_s1 <= 1'b0;
		end else begin
			if (req.slot_we) begin
				slot_vld_q[req.slot_wa] <= 1'b1;
			end
			if (req.time_we) begin
				time_vld_q[req.time_wa] <= 1'b1;
			end
			slot_rv_s1 <= slot_vld_q[req.slot_ra];
			time_rv_s1 <= time_vld_q[req.time_ra];
		end
	end

	// never-written entries read as zero
	assign rsp.slot_addr = slot_rv_s1 ? slot_rd_s1[ADDR_W+SEC_W-1:SEC_W] : '0;
	assign rsp.slot_blk  = slot_rv_s1 ? slot_rd_s1[SEC_W-1:0] : '0;
	assign rsp.time_val  = time_rv_s1 ? time_rd_s1 : '0;

endmodule
`default_nettype wire

// File: rtl/core/per_source_connect_rate_limiter.sv
// Top level: per-source connection rate limiter, sequencer over the slot store.
//
// channel   | handshake              | payload
// ----------+------------------------+----------------------------------------
// input     | in_valid / in_ready    | source_addr, now_seconds, trusted
// output    | out_valid / out_ready  | allowed
// config    | cfg_we                 | cfg_index, cfg_data
//
// Bypassed transactions skip the table entirely; a zero address skips the slot scan.
// A full check makes 15 slot reads, then reads the chosen slot and
// its 4 attempt times, each through the registered memory read port.
// One transaction in flight; in_ready is high only when the sequencer is idle.
// The result register holds while out_ready is low; a new transaction can be
// accepted meanwhile. Reset clears all table entries at once via valid bits.
`timescale 1ns / 1ps
`default_nettype none
module per_source_connect_rate_limiter
	import psrl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [ADDR_W-1:0]    source_addr,
	input  wire logic [SEC_W-1:0]     now_seconds,
	input  wire logic                 trusted,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      allowed,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DELAY_W-1:0]   cfg_data
);

	state_t              state_q, state_d;
	store_req_t          req;
	store_rsp_t          rsp;

	logic [DELAY_W-1:0]  delay_q;
	logic                force_q;
	logic                out_valid_q;
	logic                allowed_q;
	logic                res_q;

	logic [ADDR_W-1:0]   addr_q;
	logic [SEC_W-1:0]    now_q;
	logic [SLOT_W-1:0]   idx_q, idx_s1;
	logic                scan_s1;
	logic                match_found_q, exp_found_q;
	logic [SLOT_W-1:0]   match_slot_q, exp_slot_q;
	logic [SLOT_W-1:0]   slot_q, chosen;

	logic [TIME_AW-1:0]  taddr_q, taddr_s1, first_addr_q;
	logic [TCNT_W-1:0]   tcnt_q;
	logic                time_s1;
	logic                first_found_q;
	logic [SEC_W-1:0]    latest_q;

	logic                in_acc;
	logic                bypass;
	logic                out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign bypass    = (trusted && !force_q) || (delay_q == '0);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign allowed   = allowed_q;
	assign chosen    = match_found_q ? match_slot_q : (exp_found_q ? exp_slot_q : '0);

	psrl_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req     = '0;
		req.slot_ra = idx_q;
		req.time_ra = taddr_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (bypass) begin
						state_d = S_DONE;
					end else if (source_addr == '0) begin
						state_d = S_SLOT_RD;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (idx_q == SLOT_W'(SLOTS - 1)) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = S_SLOT_RD;
			end
			S_SLOT_RD: begin
				req.slot_ra = chosen;
				state_d     = S_SLOT_CHK;
			end
			S_SLOT_CHK: begin
				if (now_q <= rsp.slot_blk) begin
					req.slot_we      = 1'b1;
					req.slot_wa      = slot_q;
					req.slot_wd_addr = rsp.slot_addr;
					req.slot_wd_blk  = sat_add(now_q, delay_q);
					state_d          = S_DONE;
				end else begin
					state_d = S_TIME;
				end
			end
			S_TIME: begin
				if (tcnt_q == TCNT_W'(TRIES - 1)) begin
					state_d = S_TIME_END;
				end
			end
			S_TIME_END: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (first_found_q) begin
					req.time_we = 1'b1;
					req.time_wa = first_addr_q;
					req.time_wd = sat_add(latest_q, delay_q);
				end else begin
					req.slot_we      = 1'b1;
					req.slot_wa      = slot_q;
					req.slot_wd_addr = addr_q;
					req.slot_wd_blk  = sat_add(latest_q, delay_q);
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q       <= '0;
			force_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			scan_s1       <= 1'b0;
			time_s1       <= 1'b0;
			idx_q         <= '0;
			tcnt_q        <= '0;
			match_found_q <= 1'b0;
			exp_found_q   <= 1'b0;
			first_found_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CONNECT_DELAY: delay_q <= cfg_data;
					REG_FORCE_VERIFY:  force_q <= cfg_data[0];
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			scan_s1 <= (state_q == S_SCAN);
			time_s1 <= (state_q == S_TIME);

			if (in_acc) begin
				idx_q         <= SLOT_W'(1);
				match_found_q <= 1'b0;
				exp_found_q   <= 1'b0;
			end else if (state_q == S_SCAN) begin
				idx_q <= idx_q + SLOT_W'(1);
			end

			if (scan_s1) begin
				if (!match_found_q && rsp.slot_addr == addr_q) begin
					match_found_q <= 1'b1;
				end
				if (!exp_found_q && now_q > rsp.slot_blk) begin
					exp_found_q <= 1'b1;
				end
			end

			if (state_q == S_SLOT_RD) begin
				tcnt_q        <= '0;
				first_found_q <= 1'b0;
			end else if (state_q == S_TIME) begin
				tcnt_q <= tcnt_q + TCNT_W'(1);
			end

			if (time_s1 && !first_found_q && rsp.time_val <= now_q) begin
				first_found_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= source_addr;
			now_q  <= now_seconds;
			res_q  <= 1'b1;
		end
		idx_s1   <= idx_q;
		taddr_s1 <= taddr_q;
		if (scan_s1) begin
			if (!match_found_q && rsp.slot_addr == addr_q) begin
				match_slot_q <= idx_s1;
			end
			if (!exp_found_q && now_q > rsp.slot_blk) begin
				exp_slot_q <= idx_s1;
			end
		end
		if (state_q == S_SLOT_RD) begin
			slot_q   <= chosen;
			taddr_q  <= TIME_AW'(chosen) * TIME_AW'(TRIES);
			latest_q <= now_q;
		end else if (state_q == S_TIME) begin
			taddr_q <= taddr_q + TIME_AW'(1);
		end
		if (state_q == S_SLOT_CHK && now_q <= rsp.slot_blk) begin
			res_q <= 1'b0;
		end
		if (time_s1) begin
			if (rsp.time_val > latest_q) begin
				latest_q <= rsp.time_val;
			end
			if (!first_found_q && rsp.time_val <= now_q) begin
				first_addr_q <= taddr_s1;
			end
		end
		if (state_q == S_UPD) begin
			res_q <= first_found_q;
		end
		if (out_load) begin
			allowed_q <= res_q;
		end
	end

	a_slot_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		req.slot_we |-> (state_q == S_SLOT_CHK || state_q == S_UPD))
		else $error("slot write outside update states");

	a_time_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		req.time_we |-> (state_q == S_UPD && first_found_q))
		else $error("attempt time write without an expired entry");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready right after accept");

	a_scan_skips_shared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q != '0))
		else $error("scan reached shared slot");

endmodule
`default_nettype wire
